>>> rtl/day_count_to_calendar_date_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the day count to calendar date block
// Each check is defined once for simulation and once as an empty body.
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_TO_CALENDAR_DATE_DEFINES_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define DC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define DC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define DC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/dc2cal_pkg.sv
// ----------------------------------------------------------------------------
// dc2cal_pkg
// Types, constants and small helper functions of the day count to calendar
// date converter.
// ----------------------------------------------------------------------------
package dc2cal_pkg;

    // Input width
    localparam int OFFSET_BITS = 20;
    localparam int S_DATA_BITS = ((OFFSET_BITS + 7) / 8) * 8;

    // Output field widths
    localparam int YEAR_BITS   = 13;
    localparam int MONTH_BITS  = 4;
    localparam int DOM_BITS    = 5;
    localparam int WDAY_BITS   = 3;
    localparam int RES_BITS    = YEAR_BITS + MONTH_BITS + DOM_BITS + WDAY_BITS;
    localparam int M_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // Calendar constants
    localparam int BASE_YEAR     = 2000;
    localparam int DAYS_400Y     = 146097;
    localparam int DAYS_100Y_L   = 36525;   // century that starts on a leap year
    localparam int DAYS_100Y     = 36524;
    localparam int DAYS_4Y       = 1461;
    localparam int DAYS_4Y_S     = 1460;    // four years that start on a common century
    localparam int DAYS_LEAP     = 366;
    localparam int DAYS_COMMON   = 365;
    localparam int BASE_WEEKDAY  = 5;       // 2000-01-01 was a Saturday

    // Remaining-days register must also hold the 400-year length
    localparam int CYCLE_LEN_BITS = $clog2(DAYS_400Y + 1);
    localparam int REM_BITS = (OFFSET_BITS > CYCLE_LEN_BITS) ? OFFSET_BITS : CYCLE_LEN_BITS;

    // Year accumulator wide enough for the largest offset, output keeps low bits
    localparam int YEAR_SPAN     = BASE_YEAR + 400 * (((2 ** OFFSET_BITS) - 1) / DAYS_400Y)
                                   + 400;
    localparam int YEAR_SPAN_BITS = $clog2(YEAR_SPAN);
    localparam int YEAR_ACC_BITS = (YEAR_SPAN_BITS > YEAR_BITS) ? YEAR_SPAN_BITS : YEAR_BITS;

    // Loop limits
    localparam logic [1:0] LAST_CENT  = 2'd3;
    localparam logic [4:0] LAST_QUAD  = 5'd24;
    localparam logic [1:0] LAST_YEAR  = 2'd3;
    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] MONTH_FEB  = 4'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CYCLE,
        ST_CENT,
        ST_QUAD,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    // Reduce a small value modulo 7 in three compare-subtract steps
    function automatic logic [2:0] mod7_small(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd28)
        begin
            t = t - 6'd28;
        end
        if (t >= 6'd14)
        begin
            t = t - 6'd14;
        end
        if (t >= 6'd7)
        begin
            t = t - 6'd7;
        end
        return t[2:0];
    endfunction

    // Month length, month numbered from 0
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3:      len = 5'd30;
            4'd5:      len = 5'd30;
            4'd8:      len = 5'd30;
            4'd10:     len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/day_count_to_calendar_date.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date
// Converts a count of days since 2000-01-01 into Gregorian year, month, day
// of month and weekday with one shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
//
//   channel   group               direction  contents
//   input     s_tvalid/tready/    in         day_offset
//             s_tdata
//   result    m_tvalid/tready/    out        year, month, day_of_month, weekday
//             m_tdata
//
// In each transaction the single subtractor strips 400-year cycles, centuries,
// four-year groups, years and months, one length per cycle.
// s_tready is high only while the sequencer is idle.
// A finished result sits in the output register; a new transaction may run
// meanwhile and waits in its last step until that register is free.
// rst_n clears the sequencer and the output valid flag asynchronously.
//
`include "day_count_to_calendar_date_defines.svh"

module day_count_to_calendar_date
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dc2cal_pkg::S_DATA_BITS-1:0]   s_tdata,  // day_offset
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dc2cal_pkg::M_DATA_BITS-1:0]   m_tdata   // year, month,
                                                           // day_of_month, weekday
);

    localparam int RB = dc2cal_pkg::REM_BITS;
    localparam int YB = dc2cal_pkg::YEAR_ACC_BITS;

    dc2cal_pkg::state_t state_reg, state_next;

    logic [RB-1:0]                          rem_reg, rem_next;
    logic [YB-1:0]                          year_reg, year_next;
    logic [1:0]                             cent_reg, cent_next;
    logic [4:0]                             quad_reg, quad_next;
    logic [1:0]                             yidx_reg, yidx_next;
    logic [3:0]                             mon_reg, mon_next;
    logic [2:0]                             acc_reg, acc_next;
    logic                                   mvalid_reg, mvalid_next;
    logic [dc2cal_pkg::M_DATA_BITS-1:0]     mdata_reg, mdata_next;

    // shared subtract-and-compare unit
    logic [RB-1:0] len_sel;
    logic [2:0]    lm_sel;
    logic [RB:0]   diff;
    logic          fits;
    logic [3:0]    acc_sum;
    logic [2:0]    acc_add;

    // calendar flags from the counters
    logic          short_quad;
    logic          leap_year;
    logic [4:0]    mlen;

    // result fields
    logic [5:0]    wd_sum;
    logic [dc2cal_pkg::WDAY_BITS-1:0]  wd_val;
    logic [dc2cal_pkg::DOM_BITS-1:0]   dom_val;
    logic [dc2cal_pkg::MONTH_BITS-1:0] month_val;

    assign short_quad = (cent_reg != 2'd0) && (quad_reg == 5'd0);
    assign leap_year  = (yidx_reg == 2'd0) && !short_quad;
    assign mlen       = dc2cal_pkg::month_len(mon_reg, leap_year);

    // length selection per phase
    always_comb
    begin
        len_sel = RB'(dc2cal_pkg::DAYS_400Y);
        lm_sel  = 3'd0;
        case (state_reg)
            dc2cal_pkg::ST_CENT:
            begin
                len_sel = (cent_reg == 2'd0) ? RB'(dc2cal_pkg::DAYS_100Y_L)
                                             : RB'(dc2cal_pkg::DAYS_100Y);
                lm_sel  = (cent_reg == 2'd0) ? 3'd6 : 3'd5;
            end
            dc2cal_pkg::ST_QUAD:
            begin
                len_sel = short_quad ? RB'(dc2cal_pkg::DAYS_4Y_S) : RB'(dc2cal_pkg::DAYS_4Y);
                lm_sel  = short_quad ? 3'd4 : 3'd5;
            end
            dc2cal_pkg::ST_YEAR:
            begin
                len_sel = leap_year ? RB'(dc2cal_pkg::DAYS_LEAP) : RB'(dc2cal_pkg::DAYS_COMMON);
                lm_sel  = leap_year ? 3'd2 : 3'd1;
            end
            dc2cal_pkg::ST_MONTH:
            begin
                len_sel = RB'(mlen);
                lm_sel  = dc2cal_pkg::mod7_small({1'b0, mlen});
            end
            default:
            begin
                len_sel = RB'(dc2cal_pkg::DAYS_400Y);
                lm_sel  = 3'd0;
            end
        endcase
    end

    assign diff    = {1'b0, rem_reg} - {1'b0, len_sel};
    assign fits    = !diff[RB];
    assign acc_sum = {1'b0, acc_reg} + {1'b0, lm_sel};
    assign acc_add = (acc_sum >= 4'd7) ? 3'(acc_sum - 4'd7) : acc_sum[2:0];

    // result formatting, remaining days are below 31 here
    assign wd_sum    = 6'(acc_reg) + 6'(dc2cal_pkg::BASE_WEEKDAY) + 6'(rem_reg[4:0]);
    assign wd_val    = dc2cal_pkg::mod7_small(wd_sum);
    assign dom_val   = rem_reg[4:0] + 5'd1;
    assign month_val = mon_reg + 4'd1;

    assign s_tready = (state_reg == dc2cal_pkg::ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // sequencer: next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        year_next   = year_reg;
        cent_next   = cent_reg;
        quad_next   = quad_reg;
        yidx_next   = yidx_reg;
        mon_next    = mon_reg;
        acc_next    = acc_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            dc2cal_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rem_next   = RB'(s_tdata[dc2cal_pkg::OFFSET_BITS-1:0]);
                    year_next  = YB'(dc2cal_pkg::BASE_YEAR);
                    cent_next  = 2'd0;
                    quad_next  = 5'd0;
                    yidx_next  = 2'd0;
                    mon_next   = 4'd0;
                    acc_next   = 3'd0;
                    state_next = dc2cal_pkg::ST_CYCLE;
                end
            end
            dc2cal_pkg::ST_CYCLE:
            begin
                if (fits)
                begin
                    rem_next  = diff[RB-1:0];
                    year_next = year_reg + YB'(400);
                end
                else
                begin
                    state_next = dc2cal_pkg::ST_CENT;
                end
            end
            dc2cal_pkg::ST_CENT:
            begin
                if (fits && (cent_reg != dc2cal_pkg::LAST_CENT))
                begin
                    rem_next  = diff[RB-1:0];
                    year_next = year_reg + YB'(100);
                    cent_next = cent_reg + 2'd1;
                    acc_next  = acc_add;
                end
                else
                begin
                    state_next = dc2cal_pkg::ST_QUAD;
                end
            end
            dc2cal_pkg::ST_QUAD:
            begin
                if (fits && (quad_reg != dc2cal_pkg::LAST_QUAD))
                begin
                    rem_next  = diff[RB-1:0];
                    year_next = year_reg + YB'(4);
                    quad_next = quad_reg + 5'd1;
                    acc_next  = acc_add;
                end
                else
                begin
                    state_next = dc2cal_pkg::ST_YEAR;
                end
            end
            dc2cal_pkg::ST_YEAR:
            begin
                if (fits && (yidx_reg != dc2cal_pkg::LAST_YEAR))
                begin
                    rem_next  = diff[RB-1:0];
                    year_next = year_reg + YB'(1);
                    yidx_next = yidx_reg + 2'd1;
                    acc_next  = acc_add;
                end
                else
                begin
                    state_next = dc2cal_pkg::ST_MONTH;
                end
            end
            dc2cal_pkg::ST_MONTH:
            begin
                if (fits && (mon_reg != dc2cal_pkg::LAST_MONTH))
                begin
                    rem_next = diff[RB-1:0];
                    mon_next = mon_reg + 4'd1;
                    acc_next = acc_add;
                end
                else
                begin
                    state_next = dc2cal_pkg::ST_DONE;
                end
            end
            dc2cal_pkg::ST_DONE:
            begin
                // wait until the output register is free
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = dc2cal_pkg::M_DATA_BITS'({wd_val, dom_val, month_val,
                                                            year_reg[dc2cal_pkg::YEAR_BITS-1:0]});
                    state_next  = dc2cal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dc2cal_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dc2cal_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        cent_reg  <= cent_next;
        quad_reg  <= quad_next;
        yidx_reg  <= yidx_next;
        mon_reg   <= mon_next;
        acc_reg   <= acc_next;
        mdata_reg <= mdata_next;
    end

    // checks
    `DC_ASSERT_NEXT(a_accept_starts, clk, rst_n, (s_tvalid && s_tready),
                    (state_reg == dc2cal_pkg::ST_CYCLE))
    `DC_ASSERT_IMPL(a_year_phase_rem, clk, rst_n, (state_reg == dc2cal_pkg::ST_YEAR),
                    (rem_reg < RB'(dc2cal_pkg::DAYS_4Y)))
    `DC_ASSERT_IMPL(a_month_phase_rem, clk, rst_n, (state_reg == dc2cal_pkg::ST_MONTH),
                    (rem_reg < RB'(dc2cal_pkg::DAYS_LEAP)))
    `DC_ASSERT_IMPL(a_result_range, clk, rst_n, m_tvalid,
                    ((m_tdata[16:13] >= 4'd1) && (m_tdata[16:13] <= 4'd12)
                     && (m_tdata[21:17] != 5'd0) && (m_tdata[24:22] <= 3'd6)))

endmodule
